>>> hdl/line_rasterizer_top_assert.svh
// assertion helpers for the line rasterizer, clocked on clk and quiet in rst
`ifndef LINE_RASTERIZER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define LR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lr_pkg.sv
`timescale 1ns / 1ps
package lr_pkg;

  // coordinate width, display up to 2^COORD_BITS square
  localparam int COORD_BITS = 8;
  localparam int DIM_W      = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int CFG_W      = 9;
  localparam int IN_W       = 16;
  localparam int COLOUR_W   = 16;
  localparam int ADDR_W     = 16;
  localparam int DIM_LIMIT  = 1 << COORD_BITS;

  // stream payload widths
  localparam int S_TDATA_W  = 5 * IN_W;
  localparam int M_TDATA_W  = ((2 * COORD_BITS + ADDR_W + COLOUR_W + 7) / 8) * 8;

  // apb map
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = CFG_W'(240);
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = CFG_W'(135);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [COLOUR_W-1:0] pen_colour;
    logic [IN_W-1:0]     end_y;
    logic [IN_W-1:0]     end_x;
    logic [IN_W-1:0]     start_y;
    logic [IN_W-1:0]     start_x;
    cmd_e                command;
  } line_cmd_t;

  typedef struct packed {
    logic                  last_pixel;
    logic [COLOUR_W-1:0]   pixel_colour;
    logic [ADDR_W-1:0]     pixel_address;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COORD_BITS-1:0] pixel_x;
  } pixel_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > DIM_LIMIT) begin
      r = DIM_W'(DIM_LIMIT);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // clamp a signed coordinate into 0..hi
  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [IN_W-1:0] v,
                                                        input logic [COORD_BITS-1:0] hi);
    logic [COORD_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(IN_W-COORD_BITS){1'b0}}, hi})) begin
      r = hi;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/lr_walk.sv
`timescale 1ns / 1ps
`include "line_rasterizer_top_assert.svh"
module lr_walk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_accept,
  input  lr_pkg::line_cmd_t         cmd,
  input  logic [lr_pkg::CFG_W-1:0]  screen_width,
  input  logic [lr_pkg::CFG_W-1:0]  screen_height,
  output logic                      pix_valid,
  output lr_pkg::pixel_t            pix
);
  import lr_pkg::*;

  logic [COORD_BITS-1:0]   walk_x, walk_y, target_x, target_y, run_x;
  logic signed [COORD_BITS:0] neg_run_y;
  logic signed [ERR_W-1:0] error_term;
  logic                    y_down;
  logic [COLOUR_W-1:0]     line_colour;
  logic                    busy;

  logic [COORD_BITS-1:0]   walk_x_next, walk_y_next, target_x_next, target_y_next, run_x_next;
  logic signed [COORD_BITS:0] neg_run_y_next;
  logic signed [ERR_W-1:0] error_term_next;
  logic                    y_down_next;
  logic [COLOUR_W-1:0]     line_colour_next;
  logic                    busy_next;

  logic [DIM_W-1:0]        eff_w, eff_h;
  logic [COORD_BITS-1:0]   wmax, hmax;
  logic [COORD_BITS-1:0]   x0c, y0c, x1c, y1c, xa, ya, xb, yb;
  logic [COORD_BITS-1:0]   load_run;
  logic signed [COORD_BITS:0] load_neg_dy;
  logic                    is_load, is_step, last;
  logic signed [ERR_W:0]   e2;
  logic                    step_x, step_y;
  logic signed [ERR_W-1:0] err_dx, err_dy;
  logic [COORD_BITS+DIM_W-1:0] row_base;

  assign eff_w = eff_dim(screen_width);
  assign eff_h = eff_dim(screen_height);
  assign wmax  = COORD_BITS'(eff_w - DIM_W'(1));
  assign hmax  = COORD_BITS'(eff_h - DIM_W'(1));

  assign is_load = cmd_accept && (cmd.command == CMD_LOAD);
  assign is_step = cmd_accept && (cmd.command == CMD_STEP) && busy;

  // endpoint clamp and swap so x runs upward
  always_comb begin
    x0c = clamp_coord(cmd.start_x, wmax);
    y0c = clamp_coord(cmd.start_y, hmax);
    x1c = clamp_coord(cmd.end_x, wmax);
    y1c = clamp_coord(cmd.end_y, hmax);
    if (x0c > x1c) begin
      xa = x1c; ya = y1c; xb = x0c; yb = y0c;
    end else begin
      xa = x0c; ya = y0c; xb = x1c; yb = y1c;
    end
    load_run = xb - xa;
    if (yb > ya) begin
      load_neg_dy = $signed({1'b0, ya}) - $signed({1'b0, yb});
    end else begin
      load_neg_dy = $signed({1'b0, yb}) - $signed({1'b0, ya});
    end
  end

  // bresenham step decisions
  assign last   = (walk_x == target_x) && (walk_y == target_y);
  assign e2     = {error_term, 1'b0};
  assign step_x = e2 >= (ERR_W+1)'(neg_run_y);
  assign step_y = e2 <= $signed({{(ERR_W+1-COORD_BITS){1'b0}}, run_x});
  assign err_dx = step_x ? ERR_W'(neg_run_y) : '0;
  assign err_dy = step_y ? $signed({{(ERR_W-COORD_BITS){1'b0}}, run_x}) : '0;

  // next state
  always_comb begin
    walk_x_next      = walk_x;
    walk_y_next      = walk_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    run_x_next       = run_x;
    neg_run_y_next   = neg_run_y;
    error_term_next  = error_term;
    y_down_next      = y_down;
    line_colour_next = line_colour;
    busy_next        = busy;
    if (is_load) begin
      walk_x_next      = xa;
      walk_y_next      = ya;
      target_x_next    = xb;
      target_y_next    = yb;
      run_x_next       = load_run;
      neg_run_y_next   = load_neg_dy;
      error_term_next  = $signed({{(ERR_W-COORD_BITS){1'b0}}, load_run}) + ERR_W'(load_neg_dy);
      y_down_next      = !(ya < yb);
      line_colour_next = cmd.pen_colour;
      busy_next        = 1'b1;
    end else if (is_step) begin
      if (last) begin
        busy_next = 1'b0;
      end else begin
        error_term_next = error_term + err_dx + err_dy;
        if (step_x) begin
          walk_x_next = walk_x + COORD_BITS'(1);
        end
        if (step_y) begin
          walk_y_next = y_down ? walk_y - COORD_BITS'(1) : walk_y + COORD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_x      <= '0;
      walk_y      <= '0;
      target_x    <= '0;
      target_y    <= '0;
      run_x       <= '0;
      neg_run_y   <= '0;
      error_term  <= '0;
      y_down      <= 1'b0;
      line_colour <= '0;
      busy        <= 1'b0;
    end else begin
      walk_x      <= walk_x_next;
      walk_y      <= walk_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      run_x       <= run_x_next;
      neg_run_y   <= neg_run_y_next;
      error_term  <= error_term_next;
      y_down      <= y_down_next;
      line_colour <= line_colour_next;
      busy        <= busy_next;
    end
  end

  // pixel of the current step, address uses the width in force now
  assign row_base = walk_y * eff_w;
  assign pix_valid = is_step;
  always_comb begin
    pix.pixel_x       = walk_x;
    pix.pixel_y       = walk_y;
    pix.pixel_address = ADDR_W'(row_base) + ADDR_W'(walk_x);
    pix.pixel_colour  = line_colour;
    pix.last_pixel    = last;
  end

  `LR_ASSERT_NEXT(a_last_ends_walk, is_step && last, !busy, "walk still busy after last pixel")
  `LR_ASSERT_NEXT(a_load_starts_walk, is_load, busy, "load did not start a walk")
  `LR_ASSERT_SAME(a_x_within_target, busy, walk_x <= target_x, "walk passed target column")

endmodule

>>> hdl/lr_out_buf.sv
`timescale 1ns / 1ps
`include "line_rasterizer_top_assert.svh"
module lr_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  lr_pkg::pixel_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lr_pkg::pixel_t out_data
);
  import lr_pkg::*;

  logic   out_valid_next, skid_valid, skid_valid_next;
  pixel_t out_data_next, skid_data, skid_data_next;
  logic   out_take;

  assign out_take = out_valid && out_ready;
  assign in_ready = !skid_valid;

  // output register refills from the skid stage first to keep order
  always_comb begin
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    skid_valid_next = skid_valid;
    skid_data_next  = skid_data;
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid_next  = 1'b1;
        out_data_next   = skid_data;
        skid_valid_next = 1'b0;
      end else if (in_valid) begin
        out_valid_next = 1'b1;
        out_data_next  = in_data;
      end else begin
        out_valid_next = 1'b0;
      end
    end else if (in_valid) begin
      skid_valid_next = 1'b1;
      skid_data_next  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data  <= out_data_next;
    skid_data <= skid_data_next;
  end

  `LR_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `LR_ASSERT_NEXT(a_stall_fills_skid, out_valid && !out_ready && in_valid, skid_valid,
                  "stalled pixel was not kept")

endmodule

>>> hdl/line_rasterizer_top.sv
`timescale 1ns / 1ps
// channel   direction  signals                               contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser     line commands
// m_*       out        m_tvalid m_tready m_tdata m_tlast     pixels
// apb       in/out     psel penable pwrite paddr pwdata ...  screen size registers
//
// one command is taken every cycle while s_tready is high; the step logic is one
// pass from the walk registers to the output or skid register
// s_tready drops only while the skid stage holds a pixel behind a stalled output
// rst is synchronous and clears the walk, so the block comes up idle at 240 x 135
module line_rasterizer_top (
  input  logic                           clk,
  input  logic                           rst,
  // start_x, start_y, end_x, end_y, pen_colour (16 bits each, lowest first)
  input  logic [lr_pkg::S_TDATA_W-1:0]   s_tdata,
  // command
  input  logic                           s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pixel_x, pixel_y, pixel_address, pixel_colour (lowest first)
  output logic [lr_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                           m_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lr_pkg::PADDR_W-1:0]     paddr,
  input  logic [lr_pkg::PDATA_W-1:0]     pwdata,
  output logic [lr_pkg::PDATA_W-1:0]     prdata,
  output logic                           pready
);
  import lr_pkg::*;

  logic [CFG_W-1:0] screen_width, screen_height;
  logic             reg_write, cmd_accept, pix_valid;
  line_cmd_t        cmd;
  pixel_t           pix, out_pix;

  // register file
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[CFG_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height);
      default:           prdata = '0;
    endcase
  end

  // command unpacking
  assign cmd_accept     = s_tvalid && s_tready;
  assign cmd.command    = cmd_e'(s_tuser);
  assign cmd.start_x    = s_tdata[IN_W-1:0];
  assign cmd.start_y    = s_tdata[2*IN_W-1:IN_W];
  assign cmd.end_x      = s_tdata[3*IN_W-1:2*IN_W];
  assign cmd.end_y      = s_tdata[4*IN_W-1:3*IN_W];
  assign cmd.pen_colour = s_tdata[5*IN_W-1:4*IN_W];

  lr_walk u_walk (
    .clk           (clk),
    .rst           (rst),
    .cmd_accept    (cmd_accept),
    .cmd           (cmd),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pix_valid     (pix_valid),
    .pix           (pix)
  );

  lr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_valid),
    .in_data   (pix),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_pix)
  );

  // pixel packing
  assign m_tdata = M_TDATA_W'({out_pix.pixel_colour, out_pix.pixel_address,
                               out_pix.pixel_y, out_pix.pixel_x});
  assign m_tlast = out_pix.last_pixel;

endmodule
